/* rtl/core/sfrc8_pkg.sv */
// Shared constants, types and a helper function of the status frame receiver.
`timescale 1ns / 1ps
package sfrc8_pkg;

  localparam int unsigned HEATERS_DEF         = 4;
  localparam int unsigned FRAME_BYTES_MAX_DEF = 64;

  localparam logic [7:0] CRC_INIT       = 8'hFF;
  localparam logic [7:0] CRC_TOP_BIT    = 8'h80;
  localparam logic [7:0] CRC_POLY_RESET = 8'h31;

  localparam logic [7:0] START_BYTE     = 8'h44;
  localparam logic [7:0] KIND_UNIT_BYTE = 8'h55;
  localparam logic [7:0] KIND_SKID_BYTE = 8'h53;

  localparam logic [5:0] HDR_KIND_POS  = 6'd2;
  localparam logic [5:0] HDR_LAST_POS  = 6'd3;
  localparam logic [5:0] FIRST_FLD_POS = 6'd4;

  localparam logic KIND_UNIT = 1'b0;
  localparam logic KIND_SKID = 1'b1;

  // Start request from the byte collector to the readout sequencer.
  typedef struct packed {
    logic start;
    logic kind;
  } rdo_req_t;

  // Number of bytes of field f; valve_fld is the index of the unit valve field.
  function automatic logic [2:0] field_size(input logic kind, input logic [4:0] f,
                                            input logic [4:0] valve_fld);
    logic [2:0] sz;
    if (f < 5'd2) begin
      sz = 3'd1;
    end else if (f == 5'd2) begin
      sz = 3'd2;
    end else if ((kind == KIND_UNIT) && (f == valve_fld)) begin
      sz = 3'd1;
    end else begin
      sz = 3'd4;
    end
    return sz;
  endfunction

endpackage

/* rtl/core/sfrc8_if.sv */
// Channel interfaces of the status frame receiver: byte input, field output, configuration.
`timescale 1ns / 1ps

interface sfrc8_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfrc8_fld_if;
  logic        valid;
  logic        ready;
  logic        frame_kind;
  logic [4:0]  field_number;
  logic [31:0] field_value;
  logic        last_field;
  modport source (output valid, output frame_kind, output field_number,
                  output field_value, output last_field, input ready);
  modport sink (input valid, input frame_kind, input field_number,
                input field_value, input last_field, output ready);
endinterface

interface sfrc8_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] crc_poly;
  modport source (output valid, output crc_poly, input ready);
  modport sink (input valid, input crc_poly, output ready);
endinterface

/* rtl/core/status_frame_receiver_crc8_core.sv */
// Top level of the status frame receiver with CRC-8 check.
`timescale 1ns / 1ps
//
// Channel  Direction  Request carries                                   Role
// cfg_i    in         crc_poly                                          sink
// rx_i     in         rx_byte                                           sink
// fld_o    out        frame_kind, field_number, field_value, last_field source
//
// While collecting, one byte request is taken in every cycle: the CRC-8 step is one
// unrolled byte update and the frame store takes one write per cycle.
// Once a frame passes its check, byte requests stall while the readout sequencer
// reads the store back, with a read and an accumulate step for each field byte
// and a put step for each field.
// The field output has its own register: a waiting field never stops collection
// once the readout is done, and readout only pauses when that register is full.
// Reset returns to hunting for the start byte, with the CRC at 0xFF and the
// polynomial at 0x31; the frame store is not cleared, as every frame writes its
// bytes before they are read back. Configuration requests are taken at once.
module status_frame_receiver_crc8_core #(
  parameter int unsigned HEATERS         = sfrc8_pkg::HEATERS_DEF,
  parameter int unsigned FRAME_BYTES_MAX = sfrc8_pkg::FRAME_BYTES_MAX_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfrc8_cfg_if.sink    cfg_i,
  sfrc8_rx_if.sink     rx_i,
  sfrc8_fld_if.source  fld_o
);
  import sfrc8_pkg::*;

  localparam int unsigned AddrW = $clog2(FRAME_BYTES_MAX);
  // Frame lengths in bytes, CRC byte included.
  localparam logic [6:0] UnitLen    = 7'(26 + 4 * HEATERS);
  localparam logic [6:0] SkidLen    = 7'd41;
  localparam logic [6:0] StoreDepth = 7'(FRAME_BYTES_MAX);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [5:0] count_q, count_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] poly_q;
  logic       kind_q, kind_d;
  logic       seen_u_q, seen_u_d;
  logic       seen_s_q, seen_s_d;

  logic             busy;
  logic             rx_acc;
  logic             take;
  logic             restart;
  logic             len_hit;
  logic [7:0]       crc_next;
  logic             wr_en;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  rdo_req_t         req;

  // The store is only read during readout, so input is held off meanwhile and
  // reads and writes never meet on the same entry.
  assign rx_i.ready  = !busy;
  assign rx_acc      = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;

  // The last byte of the frame is the one whose position reaches the length.
  assign len_hit = (({1'b0, count_q} + 7'd1) >= ((kind_q == KIND_SKID) ? SkidLen : UnitLen));

  sfrc8_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (rx_i.rx_byte),
    .poly_i (poly_q),
    .crc_o  (crc_next)
  );

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    crc_d     = crc_q;
    kind_d    = kind_q;
    seen_u_d  = seen_u_q;
    seen_s_d  = seen_s_q;
    take      = 1'b0;
    restart   = 1'b0;
    req.start = 1'b0;
    req.kind  = kind_q;

    if (rx_acc) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_i.rx_byte == START_BYTE) begin
            take    = 1'b1;
            phase_d = PH_HEADER;
          end
        end
        PH_HEADER: begin
          take = 1'b1;
          if (count_q == HDR_KIND_POS) begin
            seen_u_d = (rx_i.rx_byte == KIND_UNIT_BYTE);
            seen_s_d = (rx_i.rx_byte == KIND_SKID_BYTE);
          end
          // The whole header is consumed before the kind is judged, so a start
          // byte inside a rejected header does not open a frame.
          if (count_q == HDR_LAST_POS) begin
            if (seen_u_q) begin
              kind_d  = KIND_UNIT;
              phase_d = PH_BODY;
            end else if (seen_s_q) begin
              kind_d  = KIND_SKID;
              phase_d = PH_BODY;
            end else begin
              restart = 1'b1;
            end
          end
        end
        PH_BODY: begin
          if (len_hit) begin
            req.start = (crc_q == rx_i.rx_byte);
            restart   = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end

    if (take) begin
      count_d = count_q + 6'd1;
      crc_d   = crc_next;
    end
    if (restart) begin
      phase_d = PH_HUNT;
      count_d = 6'd0;
      crc_d   = CRC_INIT;
    end
  end

  // Bytes at positions past the store still enter the CRC but are not kept.
  assign wr_en = take && ({1'b0, count_q} < StoreDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      count_q  <= 6'd0;
      crc_q    <= CRC_INIT;
      poly_q   <= CRC_POLY_RESET;
      kind_q   <= KIND_UNIT;
      seen_u_q <= 1'b0;
      seen_s_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      kind_q   <= kind_d;
      seen_u_q <= seen_u_d;
      seen_s_q <= seen_s_d;
      if (cfg_i.valid && cfg_i.ready) begin
        poly_q <= cfg_i.crc_poly;
      end
    end
  end

  sfrc8_ram #(
    .Width (8),
    .Depth (FRAME_BYTES_MAX)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (rx_i.rx_byte),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sfrc8_readout #(
    .Heaters       (HEATERS),
    .FrameBytesMax (FRAME_BYTES_MAX)
  ) u_readout (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .busy_o    (busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .fld_o     (fld_o)
  );

  // While hunting, no frame is open: the CRC and position are at their start values.
  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT) |-> ((crc_q == CRC_INIT) && (count_q == 6'd0)))
    else $error("hunt phase entered with a frame still open");

  // A readout is only started from the frame body, and the sequencer is busy next.
  a_start_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> ((phase_q == PH_BODY) && !busy))
    else $error("readout started outside the frame body");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |=> busy)
    else $error("readout sequencer did not take the start request");

  // The store is never written while a frame is being read back.
  a_no_write_in_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !wr_en)
    else $error("frame store written during readout");

endmodule

/* rtl/core/sfrc8_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sfrc8_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/sfrc8_crc.sv */
// One byte step of an MSB-first CRC-8 with a programmable polynomial.
`timescale 1ns / 1ps
module sfrc8_crc (
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] poly_i,
  output logic [7:0] crc_o
);
  import sfrc8_pkg::*;

  always_comb begin
    logic [7:0] c;
    c = crc_i ^ byte_i;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP_BIT) != 8'd0) begin
        c = (c << 1) ^ poly_i;
      end else begin
        c = c << 1;
      end
    end
    crc_o = c;
  end

endmodule

/* rtl/core/sfrc8_readout.sv */
// Readout sequencer: reads a checked frame back from the store and presents its fields.
`timescale 1ns / 1ps
module sfrc8_readout #(
  parameter int unsigned Heaters       = sfrc8_pkg::HEATERS_DEF,
  parameter int unsigned FrameBytesMax = sfrc8_pkg::FRAME_BYTES_MAX_DEF,
  localparam int unsigned AddrW = $clog2(FrameBytesMax)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfrc8_pkg::rdo_req_t  req_i,
  output logic                 busy_o,
  output logic                 rd_en_o,
  output logic [AddrW-1:0]     rd_addr_o,
  input  logic [7:0]           rd_data_i,
  sfrc8_fld_if.source          fld_o
);
  import sfrc8_pkg::*;

  localparam logic [4:0] ValveFld      = 5'(3 + Heaters);
  localparam logic [4:0] UnitLastField = 5'(7 + Heaters);
  localparam logic [4:0] SkidLastField = 5'd10;
  localparam logic [6:0] StoreDepth    = 7'(FrameBytesMax);

  typedef enum logic [3:0] {
    RO_IDLE = 4'b0001,
    RO_READ = 4'b0010,
    RO_ACC  = 4'b0100,
    RO_PUT  = 4'b1000
  } ro_state_e;

  ro_state_e   state_q, state_d;
  logic [4:0]  field_q, field_d;
  logic        kind_q, kind_d;
  logic [5:0]  pos_q, pos_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic        oob_q, oob_d;

  logic        out_valid_q, out_valid_d;
  logic        out_kind_q, out_kind_d;
  logic [4:0]  out_num_q, out_num_d;
  logic [31:0] out_val_q, out_val_d;
  logic        out_last_q, out_last_d;

  logic       out_free;
  logic       is_last;
  logic [7:0] rd_byte;

  assign out_free = !out_valid_q || fld_o.ready;
  assign is_last  = (field_q == ((kind_q == KIND_SKID) ? SkidLastField : UnitLastField));
  // Positions beyond the store read as zero.
  assign rd_byte  = oob_q ? 8'd0 : rd_data_i;

  always_comb begin
    state_d     = state_q;
    field_d     = field_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    left_d      = left_q;
    acc_d       = acc_q;
    oob_d       = oob_q;
    out_valid_d = out_valid_q && !fld_o.ready;
    out_kind_d  = out_kind_q;
    out_num_d   = out_num_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    rd_en_o     = 1'b0;

    unique case (state_q)
      RO_IDLE: begin
        if (req_i.start) begin
          kind_d  = req_i.kind;
          field_d = 5'd0;
          pos_d   = FIRST_FLD_POS;
          left_d  = 3'd1;
          acc_d   = 32'd0;
          state_d = RO_READ;
        end
      end
      RO_READ: begin
        rd_en_o = 1'b1;
        oob_d   = ({1'b0, pos_q} >= StoreDepth);
        pos_d   = pos_q + 6'd1;
        state_d = RO_ACC;
      end
      RO_ACC: begin
        acc_d   = {acc_q[23:0], rd_byte};
        left_d  = left_q - 3'd1;
        state_d = (left_q == 3'd1) ? RO_PUT : RO_READ;
      end
      RO_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_num_d   = field_q;
          out_val_d   = acc_q;
          out_last_d  = is_last;
          if (is_last) begin
            state_d = RO_IDLE;
          end else begin
            field_d = field_q + 5'd1;
            left_d  = field_size(kind_q, field_q + 5'd1, ValveFld);
            acc_d   = 32'd0;
            state_d = RO_READ;
          end
        end
      end
      default: begin
        state_d = RO_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= RO_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    field_q    <= field_d;
    kind_q     <= kind_d;
    pos_q      <= pos_d;
    left_q     <= left_d;
    acc_q      <= acc_d;
    oob_q      <= oob_d;
    out_kind_q <= out_kind_d;
    out_num_q  <= out_num_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign busy_o             = (state_q != RO_IDLE);
  assign rd_addr_o          = pos_q[AddrW-1:0];
  assign fld_o.valid        = out_valid_q;
  assign fld_o.frame_kind   = out_kind_q;
  assign fld_o.field_number = out_num_q;
  assign fld_o.field_value  = out_val_q;
  assign fld_o.last_field   = out_last_q;

endmodule
